// ===== rtl/core/c3u_pkg.sv =====
// Package: shared constants, command codes and types for the 3x3 convolution unit
package c3u_pkg;

    localparam int MAX_HEIGHT       = 32;
    localparam int MAX_WIDTH        = 32;
    localparam int MAX_IN_CHANNELS  = 64;
    localparam int MAX_OUT_CHANNELS = 16;
    localparam int TAPS             = 9;

    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int IW = $clog2(MAX_IN_CHANNELS);
    localparam int OW = $clog2(MAX_OUT_CHANNELS);

    localparam int ACC_DEPTH = MAX_OUT_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int AAW       = $clog2(ACC_DEPTH);
    localparam int ACC_W     = 48;

    localparam logic [2:0] CMD_WEIGHT = 3'd0;
    localparam logic [2:0] CMD_BIAS   = 3'd1;
    localparam logic [2:0] CMD_START  = 3'd2;
    localparam logic [2:0] CMD_SAMPLE = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [2:0] REG_HEIGHT = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_IN_CH  = 3'd2;
    localparam logic [2:0] REG_OUT_CH = 3'd3;
    localparam logic [2:0] REG_BIAS   = 3'd4;
    localparam logic [2:0] REG_LOW    = 3'd5;
    localparam logic [2:0] REG_HIGH   = 3'd6;

    // one accumulate operation from the sequencer to the accumulator memory
    typedef struct packed {
        logic               valid;
        logic [AAW-1:0]     addr;
        logic signed [31:0] prod;
    } acc_op_t;

endpackage

// ===== rtl/core/conv3x3_same_bias_clamp_unit.sv =====
// Top level: command decode, tap sequencer, clear sweep and read-out of the 3x3 convolution unit
//
// Usage: drive start with a command and its fields; the item is taken when busy is low.
// Load weight and load bias leave busy low. A read holds busy high in the read state;
// the accumulator entry and bias are read into registers, then the clamped sum is
// registered into result with result_valid. Start image runs a clear sweep over all
// 16384 accumulator entries, one per cycle, with busy high. A sample walks the output
// channels in use and the nine taps with one multiplier, then passes a drain state in
// which the weight memory read port and the accumulator read-modify-write finish; busy
// stays high throughout, so no new item is taken until the sample is done.
// Configuration writes take effect at once and are allowed while busy is low.
// Reset: busy rises, configuration returns to its reset values, the accumulator
// memory is zeroed through a clear sweep over all 16384 entries run right after reset.
// Results appear on result with result_valid high for one cycle; the receiver
// cannot stall them.
module conv3x3_same_bias_clamp_unit
    import c3u_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         command,
    input  logic [3:0]         out_channel,
    input  logic [5:0]         in_channel,
    input  logic [1:0]         kernel_row,
    input  logic [1:0]         kernel_col,
    input  logic [4:0]         pixel_row,
    input  logic [4:0]         pixel_col,
    input  logic signed [15:0] value,
    input  logic signed [31:0] bias_value,
    output logic               result_valid,
    output logic signed [31:0] result
);

    localparam int WAW = $clog2(MAX_OUT_CHANNELS*MAX_IN_CHANNELS*TAPS);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SAMPLE = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_READ   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0]         height_reg, width_reg;
    logic [6:0]         in_ch_reg;
    logic [4:0]         out_ch_reg;
    logic               use_bias_reg;
    logic signed [31:0] low_reg, high_reg;
    logic signed [31:0] bias_mem [MAX_OUT_CHANNELS];

    logic [5:0] h_use, w_use;
    logic [6:0] nic;
    logic [4:0] noc;

    logic [AAW-1:0]     clr_reg;
    logic [OW:0]        oc_reg;
    logic [3:0]         tap_reg;
    logic [1:0]         drain_reg;
    logic [RW-1:0]      pr_reg;
    logic [CW-1:0]      pc_reg;
    logic [IW-1:0]      ic_reg;
    logic signed [15:0] val_reg;
    logic [OW-1:0]      rd_oc_reg;
    logic               rd_ok_reg;
    logic [1:0]         rd_ph_reg;

    logic               t0_valid_reg;
    logic [AAW-1:0]     t0_addr_reg;
    logic signed [15:0] w_q;
    acc_op_t            op;

    logic               accept;
    logic [1:0]         kh, kw;
    logic [RW+1:0]      orow;
    logic [CW+1:0]      ocol;
    logic               tap_ok;

    logic               wr_w;
    logic [WAW-1:0]     w_waddr, w_raddr;
    logic signed [ACC_W-1:0] acc_q;
    logic signed [ACC_W:0]   s_full;
    logic signed [31:0]      bias_q_reg;

    always_comb
    begin
        h_use = (height_reg == 6'd0) ? 6'd1 : (height_reg > 6'(MAX_HEIGHT) ? 6'(MAX_HEIGHT) : height_reg);
        w_use = (width_reg == 6'd0) ? 6'd1 : (width_reg > 6'(MAX_WIDTH) ? 6'(MAX_WIDTH) : width_reg);
        nic   = (in_ch_reg == 7'd0) ? 7'd1 : (in_ch_reg > 7'(MAX_IN_CHANNELS) ? 7'(MAX_IN_CHANNELS) : in_ch_reg);
        noc   = (out_ch_reg == 5'd0) ? 5'd1 : (out_ch_reg > 5'(MAX_OUT_CHANNELS) ? 5'(MAX_OUT_CHANNELS) : out_ch_reg);
    end

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg   <= 6'd32;
            width_reg    <= 6'd32;
            in_ch_reg    <= 7'd1;
            out_ch_reg   <= 5'd1;
            use_bias_reg <= 1'b0;
            low_reg      <= 32'sh8000_0000;
            high_reg     <= 32'sh7FFF_FFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEIGHT: height_reg   <= cfg_data[5:0];
                REG_WIDTH:  width_reg    <= cfg_data[5:0];
                REG_IN_CH:  in_ch_reg    <= cfg_data[6:0];
                REG_OUT_CH: out_ch_reg   <= cfg_data[4:0];
                REG_BIAS:   use_bias_reg <= cfg_data[0];
                REG_LOW:    low_reg      <= cfg_data;
                REG_HIGH:   high_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_BIAS)
            bias_mem[out_channel] <= bias_value;
        bias_q_reg <= bias_mem[rd_oc_reg];
    end

    // tap decode
    always_comb
    begin
        case (tap_reg)
            4'd0: begin kh = 2'd0; kw = 2'd0; end
            4'd1: begin kh = 2'd0; kw = 2'd1; end
            4'd2: begin kh = 2'd0; kw = 2'd2; end
            4'd3: begin kh = 2'd1; kw = 2'd0; end
            4'd4: begin kh = 2'd1; kw = 2'd1; end
            4'd5: begin kh = 2'd1; kw = 2'd2; end
            4'd6: begin kh = 2'd2; kw = 2'd0; end
            4'd7: begin kh = 2'd2; kw = 2'd1; end
            default: begin kh = 2'd2; kw = 2'd2; end
        endcase
        orow   = (RW+2)'(pr_reg) + (RW+2)'(1) - (RW+2)'(kh);
        ocol   = (CW+2)'(pc_reg) + (CW+2)'(1) - (CW+2)'(kw);
        tap_ok = (state_reg == ST_SAMPLE) && (orow < (RW+2)'(h_use)) && (ocol < (CW+2)'(w_use));
    end

    assign wr_w = accept && command == CMD_WEIGHT && kernel_row != 2'd3 && kernel_col != 2'd3;
    assign w_waddr = WAW'((({OW'(0), out_channel} * MAX_IN_CHANNELS + in_channel) * TAPS)
                     + kernel_row * 3 + kernel_col);
    assign w_raddr = WAW'(((oc_reg[OW-1:0] * MAX_IN_CHANNELS + ic_reg) * TAPS) + tap_reg);

    c3u_weight_mem u_wmem (
        .clk   (clk),
        .we    (wr_w),
        .waddr (w_waddr),
        .wdata (value),
        .raddr (w_raddr),
        .rdata (w_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t0_valid_reg <= 1'b0;
        else
            t0_valid_reg <= tap_ok;
    end

    always_ff @(posedge clk)
    begin
        t0_addr_reg <= AAW'((oc_reg[OW-1:0] * MAX_HEIGHT + orow[RW-1:0]) * MAX_WIDTH + ocol[CW-1:0]);
    end

    assign op.valid = t0_valid_reg;
    assign op.addr  = t0_addr_reg;
    assign op.prod  = val_reg * w_q;

    c3u_acc_mem u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .clear_en   (state_reg == ST_CLEAR),
        .clear_addr (clr_reg),
        .rd_en      (state_reg == ST_READ),
        .rd_addr    (AAW'((rd_oc_reg * MAX_HEIGHT + pr_reg) * MAX_WIDTH + pc_reg)),
        .rd_data    (acc_q)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_reg == AAW'(ACC_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (accept)
                begin
                    case (command)
                        CMD_START: state_next = ST_CLEAR;
                        CMD_SAMPLE:
                            if (7'(in_channel) < nic && 6'(pixel_row) < h_use && 6'(pixel_col) < w_use)
                                state_next = ST_SAMPLE;
                        CMD_READ: state_next = ST_READ;
                        default: ;
                    endcase
                end
            ST_SAMPLE:
                if (tap_reg == 4'd8 && oc_reg == (OW+1)'(noc - 5'd1)) state_next = ST_DRAIN;
            ST_DRAIN:  if (drain_reg == 2'd2) state_next = ST_IDLE;
            ST_READ:   if (rd_ph_reg == 2'd1) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            oc_reg       <= '0;
            tap_reg      <= '0;
            drain_reg    <= '0;
            rd_ph_reg    <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= (state_reg == ST_READ) && rd_ph_reg == 2'd1;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            else
                clr_reg <= '0;
            if (state_reg == ST_SAMPLE)
            begin
                if (tap_reg == 4'd8)
                begin
                    tap_reg <= '0;
                    oc_reg  <= oc_reg + 1'b1;
                end
                else
                    tap_reg <= tap_reg + 1'b1;
            end
            else
            begin
                tap_reg <= '0;
                oc_reg  <= '0;
            end
            drain_reg <= (state_reg == ST_DRAIN) ? drain_reg + 1'b1 : 2'd0;
            rd_ph_reg <= (state_reg == ST_READ) ? rd_ph_reg + 1'b1 : 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pr_reg    <= pixel_row;
            pc_reg    <= pixel_col;
            ic_reg    <= in_channel;
            val_reg   <= value;
            rd_oc_reg <= out_channel;
            rd_ok_reg <= 5'(out_channel) < noc && 6'(pixel_row) < h_use && 6'(pixel_col) < w_use;
        end
    end

    assign s_full = {acc_q[ACC_W-1], acc_q}
                  + (use_bias_reg ? (ACC_W+1)'(bias_q_reg) : '0);

    always_ff @(posedge clk)
    begin
        if (!rd_ok_reg)
            result <= '0;
        else if (s_full < (ACC_W+1)'(low_reg) || low_reg > high_reg)
            result <= low_reg;
        else if (s_full > (ACC_W+1)'(high_reg))
            result <= high_reg;
        else
            result <= s_full[31:0];
    end

    a_result_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_READ)) else $error("stray result");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !accept) else $error("accept while busy");
    a_tap_only_sample: assert property (@(posedge clk) disable iff (!rst_n)
        t0_valid_reg |-> $past(state_reg == ST_SAMPLE)) else $error("stray tap");

endmodule

// ===== rtl/core/c3u_acc_mem.sv =====
// Accumulator memory: read-modify-write with saturation, clear sweep, read port
module c3u_acc_mem
    import c3u_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  acc_op_t                 op,
    input  logic                    clear_en,
    input  logic [AAW-1:0]          clear_addr,
    input  logic                    rd_en,
    input  logic [AAW-1:0]          rd_addr,
    output logic signed [ACC_W-1:0] rd_data
);

    logic signed [ACC_W-1:0] mem [ACC_DEPTH];
    logic signed [ACC_W-1:0] q_reg;
    logic                    s1_valid_reg;
    logic [AAW-1:0]          s1_addr_reg;
    logic signed [31:0]      s1_prod_reg;
    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W-1:0] sat;
    logic signed [ACC_W-1:0] cur;
    logic                    fwd_reg;
    logic signed [ACC_W-1:0] wb_reg;

    localparam logic signed [ACC_W:0] AMAX = {2'b00, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W:0] AMIN = {2'b11, {(ACC_W-1){1'b0}}};

    function automatic logic signed [ACC_W:0] op_prod_ext(input logic signed [31:0] p);
        op_prod_ext = {{(ACC_W-31){p[31]}}, p};
    endfunction

    always_ff @(posedge clk)
    begin
        if (op.valid)
            q_reg <= mem[op.addr];
        else
            q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= op.valid;
            fwd_reg      <= op.valid && s1_valid_reg && (op.addr == s1_addr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= op.addr;
        s1_prod_reg <= op.prod;
        wb_reg      <= sat;
    end

    assign cur = fwd_reg ? wb_reg : q_reg;
    assign sum = {cur[ACC_W-1], cur} + op_prod_ext(s1_prod_reg);

    always_comb
    begin
        if (sum > AMAX)
            sat = AMAX[ACC_W-1:0];
        else if (sum < AMIN)
            sat = AMIN[ACC_W-1:0];
        else
            sat = sum[ACC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (clear_en)
            mem[clear_addr] <= '0;
        else if (s1_valid_reg)
            mem[s1_addr_reg] <= sat;
    end

    assign rd_data = q_reg;

    a_no_rd_during_op: assert property (@(posedge clk) disable iff (!rst_n)
        op.valid |-> !rd_en) else $error("read collides with accumulate");
    a_no_clear_during_op: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !clear_en) else $error("clear collides with write-back");
    a_fwd_same: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg && $past(s1_valid_reg)) else $error("bad forward");

endmodule

// ===== rtl/core/c3u_weight_mem.sv =====
// Weight memory: one write port and one registered read port
module c3u_weight_mem
    import c3u_pkg::*;
(
    input  logic                    clk,
    input  logic                    we,
    input  logic [$clog2(MAX_OUT_CHANNELS*MAX_IN_CHANNELS*TAPS)-1:0] waddr,
    input  logic signed [15:0]      wdata,
    input  logic [$clog2(MAX_OUT_CHANNELS*MAX_IN_CHANNELS*TAPS)-1:0] raddr,
    output logic signed [15:0]      rdata
);

    logic signed [15:0] mem [MAX_OUT_CHANNELS*MAX_IN_CHANNELS*TAPS];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
